// File: design/smwp_pkg.sv
// ---------------------------------------------------------------------------
// smwp_pkg
// Shared types and constants of the skyline min-waste packer.
// ---------------------------------------------------------------------------
package smwp_pkg;

    // coordinate and area widths
    localparam int CW     = 15;
    localparam int AREA_W = 29;
    localparam int TAG_W  = 32;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    // result status codes
    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BIN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BIN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROT_EN     = 2'd2;

    // one skyline segment
    typedef struct packed {
        logic [CW-1:0] l;
        logic [CW-1:0] t;
        logic [CW-1:0] s;
    } t_seg;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic cand_init;
        logic scan_ex;
        logic fit_mul;
        logic fit_cmp;
        logic pl_init;
        logic pl_a;
        logic pl_b;
        logic pl_c;
        logic pl_tail;
        logic pl_flush;
        logic pl_end;
        logic area_mul;
        logic area_add;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic zero_side;
        logic scan_more;
        logic cand_left;
        logic found_any;
        logic place_more;
        logic full;
    } t_sts;

endpackage

// File: design/smwp_ctrl.sv
// ---------------------------------------------------------------------------
// smwp_ctrl
// Sequencer of the packer: candidate scan, placement rebuild, area update.
// ---------------------------------------------------------------------------
module smwp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  smwp_pkg::t_sts i_sts,
    output smwp_pkg::t_cmd o_cmd,
    output logic           busy,
    output logic           o_valid
);
    import smwp_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE     = 18'b000000000000000001,
        S_CHECK    = 18'b000000000000000010,
        S_CAND     = 18'b000000000000000100,
        S_SC_RD    = 18'b000000000000001000,
        S_SC_EX    = 18'b000000000000010000,
        S_FIT_MUL  = 18'b000000000000100000,
        S_FIT_CMP  = 18'b000000000001000000,
        S_PL_INIT  = 18'b000000000010000000,
        S_PL_RD    = 18'b000000000100000000,
        S_PL_A     = 18'b000000001000000000,
        S_PL_B     = 18'b000000010000000000,
        S_PL_C     = 18'b000000100000000000,
        S_PL_TAIL  = 18'b000001000000000000,
        S_PL_FLUSH = 18'b000010000000000000,
        S_PL_END   = 18'b000100000000000000,
        S_AREA_MUL = 18'b001000000000000000,
        S_AREA_ADD = 18'b010000000000000000,
        S_DONE     = 18'b100000000000000000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK:    n_state = i_sts.zero_side ? S_DONE : S_CAND;
            S_CAND: begin
                o_cmd.cand_init = 1'b1;
                n_state         = S_SC_RD;
            end
            S_SC_RD:    n_state = S_SC_EX;
            S_SC_EX: begin
                o_cmd.scan_ex = 1'b1;
                n_state       = i_sts.scan_more ? S_SC_RD : S_FIT_MUL;
            end
            S_FIT_MUL: begin
                o_cmd.fit_mul = 1'b1;
                n_state       = S_FIT_CMP;
            end
            S_FIT_CMP: begin
                o_cmd.fit_cmp = 1'b1;
                if (i_sts.cand_left) begin
                    n_state = S_CAND;
                end else if (i_sts.found_any) begin
                    n_state = S_PL_INIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PL_INIT: begin
                o_cmd.pl_init = 1'b1;
                n_state       = S_PL_RD;
            end
            S_PL_RD:    n_state = S_PL_A;
            S_PL_A: begin
                o_cmd.pl_a = 1'b1;
                n_state    = S_PL_B;
            end
            S_PL_B: begin
                o_cmd.pl_b = 1'b1;
                n_state    = S_PL_C;
            end
            S_PL_C: begin
                o_cmd.pl_c = 1'b1;
                n_state    = i_sts.place_more ? S_PL_RD : S_PL_TAIL;
            end
            S_PL_TAIL: begin
                o_cmd.pl_tail = 1'b1;
                n_state       = S_PL_FLUSH;
            end
            S_PL_FLUSH: begin
                o_cmd.pl_flush = 1'b1;
                n_state        = S_PL_END;
            end
            S_PL_END: begin
                o_cmd.pl_end = 1'b1;
                n_state      = i_sts.full ? S_DONE : S_AREA_MUL;
            end
            S_AREA_MUL: begin
                o_cmd.area_mul = 1'b1;
                n_state        = S_AREA_ADD;
            end
            S_AREA_ADD: begin
                o_cmd.area_add = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// File: design/smwp_dp.sv
// ---------------------------------------------------------------------------
// smwp_dp
// Datapath: configuration, double-banked skyline store, fit scan, rebuild.
// ---------------------------------------------------------------------------
module smwp_dp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [smwp_pkg::CW-1:0]       i_cfg_data,
    input  logic [smwp_pkg::CW-1:0]       i_rect_width,
    input  logic [smwp_pkg::CW-1:0]       i_rect_height,
    input  logic [smwp_pkg::TAG_W-1:0]    i_patch_tag,
    input  smwp_pkg::t_cmd                i_cmd,
    output smwp_pkg::t_sts                o_sts,
    output logic [1:0]                    o_status,
    output logic [13:0]                   o_pos_x,
    output logic [13:0]                   o_pos_y,
    output logic                          o_rotated,
    output logic [smwp_pkg::CW-1:0]       o_placed_width,
    output logic [smwp_pkg::CW-1:0]       o_placed_height,
    output logic [smwp_pkg::AREA_W-1:0]   o_area_used,
    output logic [smwp_pkg::TAG_W-1:0]    o_tag_out
);
    import smwp_pkg::*;

    localparam int IW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNTW  = $clog2(MAX_SEGMENTS + 3);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int LW    = CW + 2;
    localparam int PW    = 2 * CW;

    // configuration and persistent state
    logic [CW-1:0]     r_bw, r_bh;
    logic              r_rot_en;
    logic              r_bank, r_fresh;
    logic [CNTW-1:0]   r_count;
    logic [AREA_W-1:0] r_area;

    // item and scan registers
    logic [CW-1:0]        r_w0, r_h0;
    logic [TAG_W-1:0]     r_tag;
    logic                 r_o;
    logic [IW-1:0]        r_i, r_ptr;
    logic [CW-1:0]        r_x, r_y;
    logic signed [LW-1:0] r_left;
    logic [PW-1:0]        r_sum, r_prod;
    logic                 r_found;
    logic [PW-1:0]        r_best_w;
    logic [CW-1:0]        r_best_y, r_bx;
    logic                 r_brot;
    logic [1:0]           r_status;

    // placement registers
    logic [CW-1:0]   r_pw, r_ph, r_top;
    logic [CW:0]     r_right;
    logic            r_ins, r_mhave;
    logic [CNTW-1:0] r_mj;
    t_seg            r_m;

    // skyline store, two banks
    t_seg            mem [DEPTH];
    t_seg            r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;

    // current segment, the initial skyline while fresh
    t_seg rd;
    always_comb begin
        rd = r_rd;
        if (r_fresh) begin
            rd = '{l: '0, t: '0, s: r_bw};
        end
    end

    // orientation under test
    logic [CW-1:0] cur_w, cur_h;
    assign cur_w = r_o ? r_h0 : r_w0;
    assign cur_h = r_o ? r_w0 : r_h0;

    // scan step: overlap of the segment with the rectangle footprint
    logic                 first;
    logic [CW-1:0]        xe;
    logic [CW:0]          sr, rgt, hi, lo;
    logic signed [LW-1:0] ov, left_nxt;
    logic                 ov_pos;
    logic [CNTW-1:0]      ptr_inc, i_inc;
    always_comb begin
        first    = (r_ptr == r_i);
        xe       = first ? rd.l : r_x;
        sr       = {1'b0, rd.l} + {1'b0, rd.s};
        rgt      = {1'b0, xe} + {1'b0, cur_w};
        hi       = (sr < rgt) ? sr : rgt;
        lo       = (rd.l > xe) ? {1'b0, rd.l} : {1'b0, xe};
        ov       = signed'({1'b0, hi}) - signed'({1'b0, lo});
        ov_pos   = (ov > 0);
        left_nxt = ov_pos ? (r_left - ov) : r_left;
        ptr_inc  = CNTW'(r_ptr) + CNTW'(1);
        i_inc    = CNTW'(r_i) + CNTW'(1);
    end

    // candidate evaluation
    logic          fit_ok, better, more_i, more_o;
    logic [PW-1:0] waste;
    always_comb begin
        fit_ok = ({1'b0, r_x} + {1'b0, cur_w} <= {1'b0, r_bw})
              && ({1'b0, r_y} + {1'b0, cur_h} <= {1'b0, r_bh});
        waste  = r_prod - r_sum;
        better = fit_ok && (!r_found || (waste < r_best_w)
              || ((waste == r_best_w) && (r_y < r_best_y)));
        more_i = (i_inc < r_count);
        more_o = !r_o && r_rot_en && (r_w0 != r_h0);
    end

    // rebuild: split of one old segment around the new top edge
    logic [CW:0] psr;
    logic        povl, push_en;
    t_seg        ins_seg, push_seg;
    always_comb begin
        psr      = {1'b0, rd.l} + {1'b0, rd.s};
        povl     = !((psr <= {1'b0, r_bx}) || ({1'b0, rd.l} >= r_right));
        ins_seg  = '{l: r_bx, t: r_top, s: r_pw};
        push_en  = 1'b0;
        push_seg = rd;
        if (i_cmd.pl_a) begin
            push_en  = povl && (rd.l < r_bx);
            push_seg = '{l: rd.l, t: rd.t, s: r_bx - rd.l};
        end else if (i_cmd.pl_b) begin
            push_en  = !r_ins && (povl || ({1'b0, rd.l} >= r_right));
            push_seg = ins_seg;
        end else if (i_cmd.pl_c) begin
            if (!povl) begin
                push_en  = 1'b1;
                push_seg = rd;
            end else begin
                push_en  = (psr > r_right);
                push_seg = '{l: r_right[CW-1:0], t: rd.t, s: CW'(psr - r_right)};
            end
        end else if (i_cmd.pl_tail) begin
            push_en  = !r_ins;
            push_seg = ins_seg;
        end
    end

    // store write of the finished merged segment
    logic merge;
    assign merge     = r_mhave && (push_seg.t == r_m.t);
    assign mem_we    = ((push_en && r_mhave && !merge) || (i_cmd.pl_flush && r_mhave))
                    && (r_mj < CNTW'(MAX_SEGMENTS));
    assign mem_waddr = {~r_bank, r_mj[IW-1:0]};

    // memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= r_m;
        end
        r_rd <= mem[{r_bank, r_ptr}];
    end

    // area sum with saturation
    logic [AREA_W+1:0] area_sum;
    assign area_sum = {2'b0, r_area} + {1'b0, r_prod[PW-1:0]};

    // control state: configuration, skyline, placement bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw     <= CW'(4096);
            r_bh     <= CW'(4096);
            r_rot_en <= 1'b1;
            r_bank   <= 1'b0;
            r_fresh  <= 1'b1;
            r_count  <= CNTW'(1);
            r_area   <= '0;
            r_found  <= 1'b0;
            r_ins    <= 1'b0;
            r_mhave  <= 1'b0;
            r_mj     <= '0;
            r_status <= ST_NOFIT;
        end else begin
            // register writes restart the skyline
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BIN_WIDTH:  r_bw     <= i_cfg_data;
                    REG_BIN_HEIGHT: r_bh     <= i_cfg_data;
                    REG_ROT_EN:     r_rot_en <= i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_idx <= REG_ROT_EN) begin
                    r_fresh <= 1'b1;
                    r_count <= CNTW'(1);
                    r_area  <= '0;
                end
            end
            if (i_cmd.latch) begin
                r_found  <= 1'b0;
                r_status <= ST_NOFIT;
            end
            if (i_cmd.fit_cmp && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.pl_init) begin
                r_ins   <= 1'b0;
                r_mhave <= 1'b0;
                r_mj    <= '0;
            end
            // merge unit
            if (push_en) begin
                r_mhave <= 1'b1;
                if (r_mhave && !merge) begin
                    r_mj <= r_mj + CNTW'(1);
                end
            end
            if (i_cmd.pl_b && push_en) begin
                r_ins <= 1'b1;
            end
            if (i_cmd.pl_flush && r_mhave) begin
                r_mj    <= r_mj + CNTW'(1);
                r_mhave <= 1'b0;
            end
            // commit the new bank or reject
            if (i_cmd.pl_end) begin
                if (r_mj > CNTW'(MAX_SEGMENTS)) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_PLACED;
                    r_bank   <= ~r_bank;
                    r_count  <= r_mj;
                    r_fresh  <= 1'b0;
                end
            end
            if (i_cmd.area_add) begin
                r_area <= (area_sum > {2'b0, AREA_MAX}) ? AREA_MAX : area_sum[AREA_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_w0  <= i_rect_width;
            r_h0  <= i_rect_height;
            r_tag <= i_patch_tag;
            r_o   <= 1'b0;
            r_i   <= '0;
        end
        if (i_cmd.cand_init) begin
            r_ptr  <= r_i;
            r_left <= signed'({2'b0, cur_w});
            r_y    <= '0;
            r_sum  <= '0;
        end
        // one covered segment per step
        if (i_cmd.scan_ex) begin
            if (first) begin
                r_x <= rd.l;
            end
            if (rd.t > r_y) begin
                r_y <= rd.t;
            end
            if (ov_pos) begin
                r_sum  <= r_sum + (rd.t * ov[CW-1:0]);
                r_left <= left_nxt;
            end
            r_ptr <= r_ptr + IW'(1);
        end
        if (i_cmd.fit_mul) begin
            r_prod <= r_y * cur_w;
        end
        if (i_cmd.fit_cmp) begin
            if (better) begin
                r_best_w <= waste;
                r_best_y <= r_y;
                r_bx     <= r_x;
                r_brot   <= r_o;
            end
            if (more_i) begin
                r_i <= r_i + IW'(1);
            end else if (more_o) begin
                r_o <= 1'b1;
                r_i <= '0;
            end
        end
        if (i_cmd.pl_init) begin
            r_pw    <= r_brot ? r_h0 : r_w0;
            r_ph    <= r_brot ? r_w0 : r_h0;
            r_top   <= r_best_y + (r_brot ? r_w0 : r_h0);
            r_right <= {1'b0, r_bx} + {1'b0, (r_brot ? r_h0 : r_w0)};
            r_ptr   <= '0;
        end
        if (i_cmd.pl_c) begin
            r_ptr <= r_ptr + IW'(1);
        end
        if (push_en) begin
            if (merge) begin
                r_m.s <= r_m.s + push_seg.s;
            end else begin
                r_m <= push_seg;
            end
        end
        if (i_cmd.area_mul) begin
            r_prod <= r_pw * r_ph;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.zero_side  = (r_w0 == '0) || (r_h0 == '0);
        o_sts.scan_more  = (left_nxt > 0) && (ptr_inc < r_count);
        o_sts.cand_left  = more_i || more_o;
        o_sts.found_any  = r_found || better;
        o_sts.place_more = (ptr_inc < r_count);
        o_sts.full       = (r_mj > CNTW'(MAX_SEGMENTS));
    end

    // result word
    logic placed;
    assign placed          = (r_status == ST_PLACED);
    assign o_status        = r_status;
    assign o_pos_x         = placed ? r_bx[13:0] : '0;
    assign o_pos_y         = placed ? r_best_y[13:0] : '0;
    assign o_rotated       = placed && r_brot;
    assign o_placed_width  = placed ? r_pw : '0;
    assign o_placed_height = placed ? r_ph : '0;
    assign o_area_used     = r_area;
    assign o_tag_out       = r_tag;

endmodule

// File: design/skyline_min_waste_packer.sv
// ---------------------------------------------------------------------------
// skyline_min_waste_packer
// Skyline bin packer choosing the position of least wasted area.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// word follows, shown for one cycle with o_valid, and it cannot be held off.
// The segment store has a single read port, so the scan is sequential: each
// candidate reads the segments that it covers one at a time, there are n
// candidates per orientation for n segments (two orientations when rotation is
// on and the sides differ), and a placement adds the rebuild and the area
// update, the area update being skipped when the store would overflow. A size
// check comes before the scan, and a rectangle with a zero side goes from it
// straight to the result. No clearing pass is needed after reset or a register
// write.
module skyline_min_waste_packer #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [smwp_pkg::CW-1:0]       i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [smwp_pkg::CW-1:0]       i_rect_width,
    input  logic [smwp_pkg::CW-1:0]       i_rect_height,
    input  logic [smwp_pkg::TAG_W-1:0]    i_patch_tag,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [13:0]                   o_pos_x,
    output logic [13:0]                   o_pos_y,
    output logic                          o_rotated,
    output logic [smwp_pkg::CW-1:0]       o_placed_width,
    output logic [smwp_pkg::CW-1:0]       o_placed_height,
    output logic [smwp_pkg::AREA_W-1:0]   o_area_used,
    output logic [smwp_pkg::TAG_W-1:0]    o_tag_out
);
    import smwp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    smwp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // datapath and segment store
    smwp_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_rect_width    (i_rect_width),
        .i_rect_height   (i_rect_height),
        .i_patch_tag     (i_patch_tag),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_rotated       (o_rotated),
        .o_placed_width  (o_placed_width),
        .o_placed_height (o_placed_height),
        .o_area_used     (o_area_used),
        .o_tag_out       (o_tag_out)
    );

endmodule

// File: design/smwp_chk.sv
// ---------------------------------------------------------------------------
// smwp_chk
// Port-level checks of the packer, bound to the top level.
// ---------------------------------------------------------------------------
module smwp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [13:0] o_pos_x,
    input logic        o_rotated,
    input logic [14:0] o_placed_width
);
    import smwp_pkg::*;

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only appears while busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result outside a busy period");

    // one result per item: strobe is a single cycle, then idle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe longer than one cycle");

    // unplaced results carry no geometry
    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_PLACED) |->
            (o_pos_x == '0 && !o_rotated && o_placed_width == '0))
        else $error("geometry on an unplaced result");

    // status code stays in range
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_PLACED || o_status == ST_NOFIT || o_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind skyline_min_waste_packer smwp_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_pos_x        (o_pos_x),
    .o_rotated      (o_rotated),
    .o_placed_width (o_placed_width)
);

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the skyline min-waste packer: a queue-fed driver
// issues rectangles, a behavioral skyline model predicts each result word and
// a monitor compares every field as it comes out.
// ---------------------------------------------------------------------------
module tb_top;
    import smwp_pkg::*;

    localparam int MAXSEG   = 64;
    localparam int WDOG_MAX = 400000;

    typedef struct {
        logic [CW-1:0]    w;
        logic [CW-1:0]    h;
        logic [TAG_W-1:0] tag;
    } t_rect;

    typedef struct {
        logic [1:0]        status;
        logic [13:0]       x;
        logic [13:0]       y;
        logic              rot;
        logic [CW-1:0]     pw;
        logic [CW-1:0]     ph;
        logic [AREA_W-1:0] area;
        logic [TAG_W-1:0]  tag;
    } t_place;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = '0;
    logic [CW-1:0]     i_cfg_data = '0;
    logic              start = 1'b0;
    logic              busy;
    logic [CW-1:0]     i_rect_width = '0;
    logic [CW-1:0]     i_rect_height = '0;
    logic [TAG_W-1:0]  i_patch_tag = '0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [13:0]       o_pos_x;
    logic [13:0]       o_pos_y;
    logic              o_rotated;
    logic [CW-1:0]     o_placed_width;
    logic [CW-1:0]     o_placed_height;
    logic [AREA_W-1:0] o_area_used;
    logic [TAG_W-1:0]  o_tag_out;

    skyline_min_waste_packer #(.MAX_SEGMENTS(MAXSEG)) uut (.*);

    always #10 i_clk = ~i_clk;

    // skyline shadow state
    longint sky_bw, sky_bh;
    bit     sky_rot_en;
    longint sky_l [MAXSEG];
    longint sky_t [MAXSEG];
    longint sky_s [MAXSEG];
    int     sky_n;
    longint used_area;

    t_rect  rect_q [$];
    t_place place_q [$];
    int     err_cnt = 0;
    int     sender_idle_pct = 0;
    int     quiet_cycles = 0;

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic void sky_clear();
        foreach (sky_l[k]) begin
            sky_l[k] = 0; sky_t[k] = 0; sky_s[k] = 0;
        end
        sky_s[0]  = sky_bw & 16'h7FFF;
        sky_n     = 1;
        used_area = 0;
    endfunction

    function automatic longint seg_overlap(int k, longint x, longint r);
        longint sl, sr, lo, hi;
        sl = sky_l[k];
        sr = sl + sky_s[k];
        lo = (sl > x) ? sl : x;
        hi = (sr < r) ? sr : r;
        return hi - lo;
    endfunction

    // resting height and waste of a w x h rectangle at segment i
    function automatic bit fit_at(int i, longint w, longint h,
                                  output longint y, output longint waste);
        longint x, r, rem, ov;
        x = sky_l[i];
        r = x + w;
        y = 0;
        waste = 0;
        if (r > sky_bw) return 0;
        rem = w;
        for (int k = i; rem > 0 && k < sky_n; k++) begin
            if (sky_t[k] > y) y = sky_t[k];
            ov = seg_overlap(k, x, r);
            if (ov > 0) rem -= ov;
        end
        if (y + h > sky_bh) return 0;
        rem = w;
        for (int k = i; rem > 0 && k < sky_n; k++) begin
            ov = seg_overlap(k, x, r);
            if (ov > 0) begin
                waste += (y - sky_t[k]) * ov;
                rem -= ov;
            end
        end
        return 1;
    endfunction

    // rebuild the skyline around a new top edge; 0 if the store overflows
    function automatic bit sky_insert(longint x, longint y, longint w, longint h);
        longint nl [MAXSEG+2];
        longint nt [MAXSEG+2];
        longint ns [MAXSEG+2];
        longint r, top, sl, sr;
        int     n, j;
        bit     ins;
        r = x + w; top = y + h; n = 0; ins = 0;
        for (int i = 0; i <= sky_n; i++) begin
            int cnt;
            longint al [3];
            longint at [3];
            longint as_ [3];
            cnt = 0;
            if (i == sky_n) begin
                if (!ins) begin al[0] = x; at[0] = top; as_[0] = w; cnt = 1; end
            end else begin
                sl = sky_l[i]; sr = sl + sky_s[i];
                if (sr <= x || sl >= r) begin
                    if (!ins && sl >= r) begin
                        al[cnt] = x; at[cnt] = top; as_[cnt] = w; cnt++; ins = 1;
                    end
                    al[cnt] = sl; at[cnt] = sky_t[i]; as_[cnt] = sky_s[i]; cnt++;
                end else begin
                    if (sl < x) begin
                        al[cnt] = sl; at[cnt] = sky_t[i]; as_[cnt] = x - sl; cnt++;
                    end
                    if (!ins) begin
                        al[cnt] = x; at[cnt] = top; as_[cnt] = w; cnt++; ins = 1;
                    end
                    if (sr > r) begin
                        al[cnt] = r; at[cnt] = sky_t[i]; as_[cnt] = sr - r; cnt++;
                    end
                end
            end
            for (int c = 0; c < cnt; c++) begin
                if (n < MAXSEG + 2) begin
                    nl[n] = al[c] & 16'h7FFF;
                    nt[n] = at[c] & 16'h7FFF;
                    ns[n] = as_[c] & 16'h7FFF;
                    n++;
                end
            end
        end
        // merge equal-height neighbors
        j = 0;
        for (int i = 1; i < n; i++) begin
            if (nt[j] == nt[i]) ns[j] = (ns[j] + ns[i]) & 16'h7FFF;
            else begin
                j++; nl[j] = nl[i]; nt[j] = nt[i]; ns[j] = ns[i];
            end
        end
        n = j + 1;
        if (n > MAXSEG) return 0;
        for (int i = 0; i < n; i++) begin
            sky_l[i] = nl[i]; sky_t[i] = nt[i]; sky_s[i] = ns[i];
        end
        sky_n = n;
        return 1;
    endfunction

    function automatic t_place pack_rect(t_rect rq);
        t_place p;
        longint w0, h0, w, h, y, waste, best_w, best_y, bx, by, a;
        bit     found, rot;
        int     orients;
        w0 = rq.w; h0 = rq.h;
        found = 0; rot = 0; bx = 0; by = 0; best_w = 0; best_y = 0;
        p = '{status: ST_NOFIT, x: '0, y: '0, rot: 1'b0, pw: '0, ph: '0,
              area: '0, tag: rq.tag};
        if (w0 != 0 && h0 != 0) begin
            orients = (sky_rot_en && w0 != h0) ? 2 : 1;
            for (int o = 0; o < orients; o++) begin
                w = o ? h0 : w0;
                h = o ? w0 : h0;
                for (int i = 0; i < sky_n; i++) begin
                    if (!fit_at(i, w, h, y, waste)) continue;
                    if (!found || waste < best_w || (waste == best_w && y < best_y)) begin
                        found = 1; best_w = waste; best_y = y;
                        bx = sky_l[i]; by = y; rot = (o != 0);
                    end
                end
            end
            if (found) begin
                w = rot ? h0 : w0;
                h = rot ? w0 : h0;
                if (sky_insert(bx, by, w, h)) begin
                    a = used_area + w * h;
                    used_area = (a > AREA_MAX) ? AREA_MAX : a;
                    p.status = ST_PLACED;
                    p.x = bx[13:0]; p.y = by[13:0]; p.rot = rot;
                    p.pw = w[CW-1:0]; p.ph = h[CW-1:0];
                end else begin
                    p.status = ST_FULL;
                end
            end
        end
        p.area = used_area[AREA_W-1:0];
        return p;
    endfunction

    // driver: one rectangle word per accepted start
    always @(posedge i_clk) begin
        if (i_rst_n && (!start || !busy)) begin
            if (start) place_q = {place_q, pack_rect('{i_rect_width, i_rect_height, i_patch_tag})};
            if (rect_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                t_rect rq;
                rq = rect_q.pop_front();
                start         <= 1'b1;
                i_rect_width  <= rq.w;
                i_rect_height <= rq.h;
                i_patch_tag   <= rq.tag;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (place_q.size() == 0) report("result word with nothing pending");
            else begin
                t_place e;
                e = place_q.pop_front();
                if (o_status !== e.status)
                    report($sformatf("status %0d exp %0d", o_status, e.status));
                if (o_pos_x !== e.x) report($sformatf("pos_x %0d exp %0d", o_pos_x, e.x));
                if (o_pos_y !== e.y) report($sformatf("pos_y %0d exp %0d", o_pos_y, e.y));
                if (o_rotated !== e.rot)
                    report($sformatf("rotated %0d exp %0d", o_rotated, e.rot));
                if (o_placed_width !== e.pw)
                    report($sformatf("placed_width %0d exp %0d", o_placed_width, e.pw));
                if (o_placed_height !== e.ph)
                    report($sformatf("placed_height %0d exp %0d", o_placed_height, e.ph));
                if (o_area_used !== e.area)
                    report($sformatf("area_used %0d exp %0d", o_area_used, e.area));
                if (o_tag_out !== e.tag)
                    report($sformatf("tag_out %h exp %h", o_tag_out, e.tag));
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("FAIL skyline_min_waste_packer");
            $finish;
        end
    end

    task automatic wait_idle();
        wait (rect_q.size() == 0 && place_q.size() == 0 && !start);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BIN_WIDTH:  sky_bw = val;
            REG_BIN_HEIGHT: sky_bh = val;
            REG_ROT_EN:     sky_rot_en = val[0];
            default: ;
        endcase
        if (idx <= REG_ROT_EN) sky_clear();
    endtask

    task automatic set_bin(int bw, int bh, bit ren);
        cfg_write(REG_BIN_WIDTH, bw[CW-1:0]);
        cfg_write(REG_BIN_HEIGHT, bh[CW-1:0]);
        cfg_write(REG_ROT_EN, {{(CW-1){1'b0}}, ren});
    endtask

    task automatic add_rect(int w, int h);
        rect_q = {rect_q, t_rect'{w[CW-1:0], h[CW-1:0], $urandom()}};
    endtask

    // mostly small rectangles, a few wild sizes and zero sides
    task automatic rand_rects(int n, int wmax, int hmax);
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 3) add_rect(0, $urandom_range(hmax));
            else if (sel < 6) add_rect($urandom_range(wmax), 0);
            else if (sel < 10) add_rect($urandom_range(32767), $urandom_range(32767));
            else add_rect($urandom_range(wmax, 1), $urandom_range(hmax, 1));
        end
    endtask

    initial begin
        sky_bw = 4096; sky_bh = 4096; sky_rot_en = 1;
        sky_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset bin, zero sides, square, exact fill, then no room
        add_rect(0, 5);
        add_rect(5, 0);
        add_rect(7, 7);
        add_rect(4089, 4096);
        add_rect(1, 1);
        add_rect(4096, 1);
        wait_idle();

        // write beyond the register list leaves the skyline alone
        cfg_write(2'd3, 15'h7FFF);
        add_rect(7, 1);
        wait_idle();

        // oversize bin: masked coordinates and area saturation
        set_bin(32767, 32767, 1);
        add_rect(20000, 1);
        add_rect(1, 20000);
        add_rect(12767, 32767);
        add_rect(32767, 32767);
        wait_idle();

        // rotation needed, then forbidden
        set_bin(10, 100, 1);
        add_rect(50, 5);
        add_rect(10, 100);
        wait_idle();
        set_bin(10, 100, 0);
        add_rect(50, 5);
        add_rect(5, 50);
        wait_idle();

        // smallest bin
        set_bin(1, 1, 1);
        add_rect(1, 1);
        add_rect(1, 1);
        wait_idle();

        // random phases over several bins and sender idling
        // results cannot be held off, so only the sender idles
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                1: sender_idle_pct = 85;
                3: sender_idle_pct = 21;
                default: sender_idle_pct = 0;
            endcase
            case (ph % 4)
                0: set_bin(200, 16384, 1);
                1: set_bin(16384, 16384, $urandom_range(1));
                2: set_bin(64, 64, 1);
                default: set_bin($urandom_range(300, 20), $urandom_range(300, 20), 0);
            endcase
            case (ph % 4)
                0: rand_rects(150, 3, 8);
                1: rand_rects(130, 4000, 4000);
                2: rand_rects(130, 12, 12);
                default: rand_rects(140, 40, 40);
            endcase
            wait_idle();
        end

        if (err_cnt == 0) $display("PASS skyline_min_waste_packer");
        else $display("FAIL skyline_min_waste_packer");
        $finish;
    end

endmodule
